// ===== hdl/imm_pkg.sv =====
// Shared types, constants and helpers for the integer matrix multiplier.
package imm_pkg;

    localparam int MAX_DIM  = 8;
    localparam int IDX_W    = $clog2(MAX_DIM);
    localparam int DIM_W    = IDX_W + 1;
    localparam int ADDR_W   = 2 * IDX_W;
    localparam int DEPTH    = MAX_DIM * MAX_DIM;
    localparam int DATA_W   = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int FIELD_W  = 2 * IDX_W + DATA_W;
    localparam int TDATA_W  = ((FIELD_W + 7) / 8) * 8;
    localparam int PAD_W    = TDATA_W - FIELD_W;
    localparam int APB_W    = 32;
    localparam int PADDR_W  = 4;
    localparam int REG_SEL_W = 2;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD_LHS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_RHS = 2'd1;
    localparam logic [KIND_W-1:0] KIND_START    = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISMATCH = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;

    // register indexes (paddr[3:2])
    localparam logic [REG_SEL_W-1:0] REG_LHS_ROWS = 2'd0;
    localparam logic [REG_SEL_W-1:0] REG_LHS_COLS = 2'd1;
    localparam logic [REG_SEL_W-1:0] REG_RHS_ROWS = 2'd2;
    localparam logic [REG_SEL_W-1:0] REG_RHS_COLS = 2'd3;

    typedef logic [DIM_W-1:0]  dim_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [DATA_W-1:0] word_t;

    typedef struct packed {
        dim_t lhs_rows;
        dim_t lhs_cols;
        dim_t rhs_rows;
        dim_t rhs_cols;
    } cfg_t;

    typedef struct packed {
        logic                lhs_we;
        logic                rhs_we;
        addr_t               waddr;
        word_t               wdata;
        logic                rd_en;
        logic                rd_first;
        logic                rd_lastk;
        addr_t               lhs_raddr;
        addr_t               rhs_raddr;
        logic                out_load;
        logic [STATUS_W-1:0] out_status;
        idx_t                out_row;
        idx_t                out_col;
        logic                out_last;
        logic                out_use_acc;
    } cmd_t;

    typedef struct packed {
        logic acc_done;
        logic out_free;
    } stat_t;

    // sizes above MAX_DIM act as MAX_DIM
    function automatic dim_t eff_dim(input dim_t d);
        return (d > dim_t'(MAX_DIM)) ? dim_t'(MAX_DIM) : d;
    endfunction

endpackage

// ===== hdl/imm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module imm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/imm_ctrl.sv =====
// Controller: accepts items, walks the i/j/k loops and issues datapath commands.
module imm_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  imm_pkg::cfg_t                 cfg,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [imm_pkg::KIND_W-1:0]    s_kind,
    input  imm_pkg::idx_t                 s_row,
    input  imm_pkg::idx_t                 s_col,
    input  imm_pkg::word_t                s_value,
    input  imm_pkg::stat_t                stat,
    output imm_pkg::cmd_t                 cmd
);

    typedef enum logic [1:0] {ST_IDLE, ST_MAC, ST_DRAIN, ST_EMIT} state_t;

    state_t                          state_reg, state_next;
    imm_pkg::idx_t                   i_reg, i_next;
    imm_pkg::idx_t                   j_reg, j_next;
    imm_pkg::idx_t                   k_reg, k_next;
    logic [imm_pkg::STATUS_W-1:0]    res_status_reg, res_status_next;
    imm_pkg::cmd_t                   cmd_reg, cmd_next;

    imm_pkg::dim_t m_eff, inner_eff, inner2_eff, n_eff;
    logic          accept, last_i, last_j, last_k, out_free, run_ok, last_elem;

    assign m_eff      = imm_pkg::eff_dim(cfg.lhs_rows);
    assign inner_eff  = imm_pkg::eff_dim(cfg.lhs_cols);
    assign inner2_eff = imm_pkg::eff_dim(cfg.rhs_rows);
    assign n_eff      = imm_pkg::eff_dim(cfg.rhs_cols);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign last_i   = ({1'b0, i_reg} == m_eff - imm_pkg::dim_t'(1));
    assign last_j   = ({1'b0, j_reg} == n_eff - imm_pkg::dim_t'(1));
    assign last_k   = ({1'b0, k_reg} == inner_eff - imm_pkg::dim_t'(1));
    // a load still in flight has not yet shown up in the output register
    assign out_free = stat.out_free && !cmd_reg.out_load;
    assign run_ok   = (res_status_reg == imm_pkg::STATUS_OK);
    assign last_elem = !run_ok || (last_i && last_j);
    assign cmd      = cmd_reg;

    always_comb
    begin
        state_next      = state_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        res_status_next = res_status_reg;
        cmd_next        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (s_kind)
                        imm_pkg::KIND_LOAD_LHS,
                        imm_pkg::KIND_LOAD_RHS:
                        begin
                            cmd_next.lhs_we = (s_kind == imm_pkg::KIND_LOAD_LHS);
                            cmd_next.rhs_we = (s_kind == imm_pkg::KIND_LOAD_RHS);
                            cmd_next.waddr  = {s_row, s_col};
                            cmd_next.wdata  = s_value;
                        end
                        imm_pkg::KIND_START:
                        begin
                            i_next = '0;
                            j_next = '0;
                            k_next = '0;
                            priority if (inner_eff != inner2_eff)
                            begin
                                res_status_next = imm_pkg::STATUS_MISMATCH;
                                state_next      = ST_EMIT;
                            end
                            else if (m_eff == '0 || n_eff == '0)
                            begin
                                res_status_next = imm_pkg::STATUS_EMPTY;
                                state_next      = ST_EMIT;
                            end
                            else
                            begin
                                res_status_next = imm_pkg::STATUS_OK;
                                state_next = (inner_eff == '0) ? ST_EMIT : ST_MAC;
                            end
                        end
                        default:
                        begin
                            // unused kind: dropped
                        end
                    endcase
                end
            end
            ST_MAC:
            begin
                cmd_next.rd_en     = 1'b1;
                cmd_next.rd_first  = (k_reg == '0);
                cmd_next.rd_lastk  = last_k;
                cmd_next.lhs_raddr = {i_reg, k_reg};
                cmd_next.rhs_raddr = {k_reg, j_reg};
                if (last_k)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + imm_pkg::idx_t'(1);
                end
            end
            ST_DRAIN:
            begin
                if (stat.acc_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd_next.out_load    = 1'b1;
                    cmd_next.out_status  = res_status_reg;
                    cmd_next.out_row     = i_reg;
                    cmd_next.out_col     = j_reg;
                    cmd_next.out_last    = last_elem;
                    cmd_next.out_use_acc = run_ok && (inner_eff != '0);
                    k_next = '0;
                    if (last_elem)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        if (last_j)
                        begin
                            j_next = '0;
                            i_next = i_reg + imm_pkg::idx_t'(1);
                        end
                        else
                        begin
                            j_next = j_reg + imm_pkg::idx_t'(1);
                        end
                        state_next = (inner_eff == '0) ? ST_EMIT : ST_MAC;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            res_status_reg <= imm_pkg::STATUS_OK;
            cmd_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            k_reg          <= k_next;
            res_status_reg <= res_status_next;
            cmd_reg        <= cmd_next;
        end
    end

endmodule

// ===== hdl/imm_dp.sv =====
// Datapath: element stores, multiply-accumulate pipeline and output register.
module imm_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  imm_pkg::cmd_t                 cmd,
    output imm_pkg::stat_t                stat,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [imm_pkg::STATUS_W-1:0]  m_status,
    output imm_pkg::idx_t                 m_row,
    output imm_pkg::idx_t                 m_col,
    output imm_pkg::word_t                m_elem,
    output logic                          m_last
);

    imm_pkg::word_t lhs_q, rhs_q;
    logic [2*imm_pkg::DATA_W-1:0] prod_full;

    logic           rd_v_reg, rd_first_reg, rd_lastk_reg;
    logic           mul_v_reg, mul_first_reg, mul_lastk_reg;
    imm_pkg::word_t prod_reg, acc_reg, acc_next;
    logic           done_reg;

    logic                         out_valid_reg;
    logic [imm_pkg::STATUS_W-1:0] out_status_reg;
    imm_pkg::idx_t                out_row_reg, out_col_reg;
    imm_pkg::word_t               out_elem_reg;
    logic                         out_last_reg;

    imm_ram #(.WIDTH(imm_pkg::DATA_W), .DEPTH(imm_pkg::DEPTH)) u_lhs_ram (
        .clk   (clk),
        .we    (cmd.lhs_we),
        .waddr (cmd.waddr),
        .wdata (cmd.wdata),
        .raddr (cmd.lhs_raddr),
        .rdata (lhs_q)
    );

    imm_ram #(.WIDTH(imm_pkg::DATA_W), .DEPTH(imm_pkg::DEPTH)) u_rhs_ram (
        .clk   (clk),
        .we    (cmd.rhs_we),
        .waddr (cmd.waddr),
        .wdata (cmd.wdata),
        .raddr (cmd.rhs_raddr),
        .rdata (rhs_q)
    );

    // low half of the product is the same for signed and unsigned operands
    assign prod_full = lhs_q * rhs_q;

    always_comb
    begin
        acc_next = acc_reg;
        if (mul_v_reg)
        begin
            acc_next = mul_first_reg ? prod_reg : acc_reg + prod_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg      <= 1'b0;
            rd_first_reg  <= 1'b0;
            rd_lastk_reg  <= 1'b0;
            mul_v_reg     <= 1'b0;
            mul_first_reg <= 1'b0;
            mul_lastk_reg <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg      <= cmd.rd_en;
            rd_first_reg  <= cmd.rd_first;
            rd_lastk_reg  <= cmd.rd_lastk;
            mul_v_reg     <= rd_v_reg;
            mul_first_reg <= rd_first_reg;
            mul_lastk_reg <= rd_lastk_reg;
            done_reg      <= mul_v_reg && mul_lastk_reg;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full[imm_pkg::DATA_W-1:0];
        acc_reg  <= acc_next;
        if (cmd.out_load)
        begin
            out_status_reg <= cmd.out_status;
            out_row_reg    <= cmd.out_row;
            out_col_reg    <= cmd.out_col;
            out_elem_reg   <= cmd.out_use_acc ? acc_reg : '0;
            out_last_reg   <= cmd.out_last;
        end
    end

    assign stat.acc_done = done_reg;
    assign stat.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_status = out_status_reg;
    assign m_row    = out_row_reg;
    assign m_col    = out_col_reg;
    assign m_elem   = out_elem_reg;
    assign m_last   = out_last_reg;

endmodule

// ===== hdl/integer_matrix_multiply.sv =====
// Top level of the signed 32-bit integer matrix multiplier.
//
// channel   dir  handshake         payload
// s_*       in   tvalid/tready     tuser: kind; tdata: row_index, col_index, value
// m_*       out  tvalid/tready     tuser: status; tdata: out_row, out_col, element; tlast
// apb       in   psel/penable      four 4-bit size registers at 0x0, 0x4, 0x8, 0xC
//
// Load items are accepted one per cycle; s_tready stays high while loading.
// A start item runs m*n elements; each issues inner multiplies, one per cycle,
// through the store read ports, then waits for the read, multiply and accumulate
// registers to drain and loads the result into the output register. With an inner
// size of zero each element is a zero result; mismatch and empty runs emit one zero item.
// s_tready is low for the whole run. A stalled m_tready holds the run at the output
// register; the next item is accepted while the final result still waits.
// Reset (rst_n, async low) clears control and sizes; the stores are not cleared.
module integer_matrix_multiply (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [imm_pkg::TDATA_W-1:0]   s_tdata,  // row_index[2:0], col_index[5:3], value[37:6]
    input  logic [imm_pkg::KIND_W-1:0]    s_tuser,  // kind[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [imm_pkg::TDATA_W-1:0]   m_tdata,  // out_row[2:0], out_col[5:3], element[37:6]
    output logic [imm_pkg::STATUS_W-1:0]  m_tuser,  // status[1:0]
    output logic                          m_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [imm_pkg::PADDR_W-1:0]   paddr,
    input  logic [imm_pkg::APB_W-1:0]     pwdata,
    output logic [imm_pkg::APB_W-1:0]     prdata,
    output logic                          pready
);

    imm_pkg::cfg_t  cfg_reg, cfg_next;
    imm_pkg::cmd_t  cmd;
    imm_pkg::stat_t stat;

    logic                           cfg_we;
    logic [imm_pkg::REG_SEL_W-1:0]  reg_sel;
    imm_pkg::dim_t                  wr_dim;

    imm_pkg::idx_t  m_row, m_col;
    imm_pkg::word_t m_elem;

    // register file: writes complete in the access phase, no wait states
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[imm_pkg::PADDR_W-1:imm_pkg::PADDR_W-imm_pkg::REG_SEL_W];
    assign wr_dim  = pwdata[imm_pkg::DIM_W-1:0];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (reg_sel)
                imm_pkg::REG_LHS_ROWS: cfg_next.lhs_rows = wr_dim;
                imm_pkg::REG_LHS_COLS: cfg_next.lhs_cols = wr_dim;
                imm_pkg::REG_RHS_ROWS: cfg_next.rhs_rows = wr_dim;
                imm_pkg::REG_RHS_COLS: cfg_next.rhs_cols = wr_dim;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            imm_pkg::REG_LHS_ROWS: prdata = imm_pkg::APB_W'(cfg_reg.lhs_rows);
            imm_pkg::REG_LHS_COLS: prdata = imm_pkg::APB_W'(cfg_reg.lhs_cols);
            imm_pkg::REG_RHS_ROWS: prdata = imm_pkg::APB_W'(cfg_reg.rhs_rows);
            imm_pkg::REG_RHS_COLS: prdata = imm_pkg::APB_W'(cfg_reg.rhs_cols);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    imm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_kind   (s_tuser),
        .s_row    (s_tdata[imm_pkg::IDX_W-1:0]),
        .s_col    (s_tdata[2*imm_pkg::IDX_W-1:imm_pkg::IDX_W]),
        .s_value  (s_tdata[imm_pkg::FIELD_W-1:2*imm_pkg::IDX_W]),
        .stat     (stat),
        .cmd      (cmd)
    );

    imm_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_status (m_tuser),
        .m_row    (m_row),
        .m_col    (m_col),
        .m_elem   (m_elem),
        .m_last   (m_tlast)
    );

    assign m_tdata = {{imm_pkg::PAD_W{1'b0}}, m_elem, m_col, m_row};

endmodule

// ===== hdl/imm_checker.sv =====
// Port-level checks for the matrix multiplier, bound to the top level.
module imm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [imm_pkg::KIND_W-1:0]    s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [imm_pkg::TDATA_W-1:0]   m_tdata,
    input logic [imm_pkg::STATUS_W-1:0]  m_tuser,
    input logic                          m_tlast
);

    a_m_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    a_m_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result item changed while stalled");

    a_special_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == imm_pkg::STATUS_MISMATCH || m_tuser == imm_pkg::STATUS_EMPTY)
        |-> m_tlast && (m_tdata == '0))
        else $error("mismatch or empty result not a lone zero item");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == imm_pkg::KIND_START) |=> !s_tready)
        else $error("input still ready after a start item");

    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready &&
        (s_tuser == imm_pkg::KIND_LOAD_LHS || s_tuser == imm_pkg::KIND_LOAD_RHS)
        |=> s_tready)
        else $error("input stalled after a load item");

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== verif/integer_matrix_multiply_test.sv =====
// Self-checking testbench for integer_matrix_multiply: directed table, random runs, stall pressure.
module integer_matrix_multiply_test;
    timeunit 1ns;
    timeprecision 1ps;

    // unused kind code; the block must ignore it
    localparam logic [imm_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS   = 230;
    localparam int NO_IDLE_TAIL   = 40;   // last items of the run go without gaps
    // covers the worst run step, an element at inner size 8; loads and
    // mismatch/empty runs finish within it
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 400;  // long output stall, counted by the receiver
    localparam int QUIET_LIMIT    = 4000; // watchdog: cycles with no handshake at all
    localparam int REPORT_LIMIT   = 10;

    typedef logic [3:0] size_t;

    // one product item as it leaves the block
    typedef struct packed {
        logic [imm_pkg::STATUS_W-1:0] status;
        imm_pkg::idx_t                row;
        imm_pkg::idx_t                col;
        imm_pkg::word_t               element;
        logic                         last;
    } product_t;

    // one store write still to be sent
    typedef struct packed {
        logic [imm_pkg::KIND_W-1:0] kind;
        imm_pkg::addr_t             addr;
    } load_t;

    typedef enum logic {ACT_SIZES, ACT_ITEM} step_act_e;

    // directed table row: either a size setting or one input item,
    // optionally with its single result typed in
    typedef struct packed {
        step_act_e                    act;
        size_t                        lhs_rows;
        size_t                        lhs_cols;
        size_t                        rhs_rows;
        size_t                        rhs_cols;
        logic [imm_pkg::KIND_W-1:0]   kind;
        imm_pkg::idx_t                row;
        imm_pkg::idx_t                col;
        imm_pkg::word_t               value;
        logic                         typed;
        logic [imm_pkg::STATUS_W-1:0] status;
        imm_pkg::word_t               element;
    } step_t;

    // ------------------------------------------------------------------
    // DUT connections; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [imm_pkg::TDATA_W-1:0]   s_tdata  = '0;  // row_index[2:0], col_index[5:3], value[37:6]
    logic [imm_pkg::KIND_W-1:0]    s_tuser  = '0;  // kind[1:0]
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [imm_pkg::TDATA_W-1:0]   m_tdata;        // out_row[2:0], out_col[5:3], element[37:6]
    logic [imm_pkg::STATUS_W-1:0]  m_tuser;        // status[1:0]
    logic                          m_tlast;
    logic                          psel     = 1'b0;
    logic                          penable  = 1'b0;
    logic                          pwrite   = 1'b0;
    logic [imm_pkg::PADDR_W-1:0]   paddr    = '0;
    logic [imm_pkg::APB_W-1:0]     pwdata   = '0;
    logic [imm_pkg::APB_W-1:0]     prdata;
    logic                          pready;

    integer_matrix_multiply u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow of the block: size registers and both element stores
    // ------------------------------------------------------------------
    size_t          size_reg [4];
    imm_pkg::word_t lhs_mem [imm_pkg::DEPTH];
    imm_pkg::word_t rhs_mem [imm_pkg::DEPTH];
    bit             lhs_set [imm_pkg::DEPTH];   // entry written since reset
    bit             rhs_set [imm_pkg::DEPTH];
    product_t       expected_products [$];

    int  fail_count      = 0;
    int  reported        = 0;
    int  items_in        = 0;   // accepted items the block acts on
    int  starts_in       = 0;
    int  products_seen   = 0;
    int  mismatch_runs   = 0;
    int  empty_runs      = 0;
    int  size_settings   = 0;
    int  quiet_cycles    = 0;
    bit  idle_on         = 1'b1;
    bit  no_idle         = 1'b0;
    bit  hold_req        = 1'b0;
    bit  hold_done       = 1'b0;

    initial
    begin
        foreach (size_reg[i]) size_reg[i] = '0;
        foreach (lhs_set[i])
        begin
            lhs_set[i] = 1'b0;
            rhs_set[i] = 1'b0;
            lhs_mem[i] = '0;
            rhs_mem[i] = '0;
        end
    end

    // sizes above the store dimension behave as the store dimension
    function automatic imm_pkg::dim_t clamp_size(input size_t d);
        return (d > size_t'(imm_pkg::MAX_DIM)) ? imm_pkg::dim_t'(imm_pkg::MAX_DIM)
                                               : imm_pkg::dim_t'(d);
    endfunction

    // Expected products of one accepted item. Loads update the shadow
    // stores; a start queues its results unless the caller types them in.
    function automatic void predict_products(input logic [imm_pkg::KIND_W-1:0] kind,
                                             input imm_pkg::idx_t row,
                                             input imm_pkg::idx_t col,
                                             input imm_pkg::word_t value,
                                             input bit emit);
        imm_pkg::addr_t a;
        imm_pkg::dim_t  m, inner, inner_r, n;
        imm_pkg::word_t acc;
        a = {row, col};
        unique case (kind)
            imm_pkg::KIND_LOAD_LHS:
            begin
                lhs_mem[a] = value;
                lhs_set[a] = 1'b1;
            end
            imm_pkg::KIND_LOAD_RHS:
            begin
                rhs_mem[a] = value;
                rhs_set[a] = 1'b1;
            end
            imm_pkg::KIND_START:
            begin
                m       = clamp_size(size_reg[imm_pkg::REG_LHS_ROWS]);
                inner   = clamp_size(size_reg[imm_pkg::REG_LHS_COLS]);
                inner_r = clamp_size(size_reg[imm_pkg::REG_RHS_ROWS]);
                n       = clamp_size(size_reg[imm_pkg::REG_RHS_COLS]);
                if (!emit)
                    return;
                if (inner != inner_r)
                    expected_products.push_back('{imm_pkg::STATUS_MISMATCH, '0, '0, '0, 1'b1});
                else if (m == 0 || n == 0)
                    expected_products.push_back('{imm_pkg::STATUS_EMPTY, '0, '0, '0, 1'b1});
                else
                begin
                    for (int i = 0; i < m; i++)
                    begin
                        for (int j = 0; j < n; j++)
                        begin
                            acc = '0;
                            // products and sums wrap at 32 bits
                            for (int k = 0; k < inner; k++)
                                acc = acc + lhs_mem[i * imm_pkg::MAX_DIM + k]
                                          * rhs_mem[k * imm_pkg::MAX_DIM + j];
                            expected_products.push_back('{imm_pkg::STATUS_OK,
                                                          imm_pkg::idx_t'(i),
                                                          imm_pkg::idx_t'(j), acc,
                                                          (i == m - 1) && (j == n - 1)});
                        end
                    end
                end
            end
            default: ;  // unused kind: no effect
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Offer one item, with an optional random gap first, and return at the
    // edge where it is accepted. Prediction happens at that same edge.
    task automatic send_item(input logic [imm_pkg::KIND_W-1:0] kind, input imm_pkg::idx_t row,
                             input imm_pkg::idx_t col, input imm_pkg::word_t value,
                             input bit emit = 1'b1);
        if (idle_on && !no_idle && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{imm_pkg::PAD_W{1'b0}}, value, col, row};
        do @(posedge clk); while (!s_tready);
        predict_products(kind, row, col, value, emit);
        if (kind != KIND_UNUSED)
            items_in++;
        if (kind == imm_pkg::KIND_START)
            starts_in++;
    endtask

    // APB write: setup then access; psel/penable are left high so that
    // back-to-back writes need only one assignment per signal per edge
    task automatic write_size(input logic [imm_pkg::REG_SEL_W-1:0] sel, input size_t value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= imm_pkg::APB_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        size_reg[sel] = value;
    endtask

    // Sizes change only once the block is idle: every product back and the
    // pipeline given time to finish any trailing load.
    task automatic set_sizes(input size_t lr, input size_t lc, input size_t rr, input size_t rc);
        s_tvalid <= 1'b0;
        while (expected_products.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_size(imm_pkg::REG_LHS_ROWS, lr);
        write_size(imm_pkg::REG_LHS_COLS, lc);
        write_size(imm_pkg::REG_RHS_ROWS, rr);
        write_size(imm_pkg::REG_RHS_COLS, rc);
        psel    <= 1'b0;
        penable <= 1'b0;
        size_settings++;
    endtask

    // element values lean on the wrap corners
    function automatic imm_pkg::word_t pick_value();
        unique case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return imm_pkg::word_t'($urandom_range(0, 16)) - 32'd8;
            default: return $urandom;
        endcase
    endfunction

    // register value for an effective size; a full size is often written
    // as an oversized value
    function automatic size_t raw_size(input int eff);
        if (eff == imm_pkg::MAX_DIM && $urandom_range(0, 1) == 1)
            return size_t'($urandom_range(imm_pkg::MAX_DIM + 1, 15));
        return size_t'(eff);
    endfunction

    // One random run: choose sizes, load what the multiply will read (in
    // shuffled order, with stray loads and unused-kind noise), then start.
    task automatic run_phase(input bit pressure);
        int             sel, m, inner, inner_r, n, starts, pick;
        imm_pkg::addr_t a;
        load_t          pending [$];
        load_t          swap;
        sel = pressure ? 0 : $urandom_range(0, 19);
        if (sel < 12)
        begin
            m = $urandom_range(1, 3);
            inner = $urandom_range(0, 3);
            inner_r = inner;
            n = $urandom_range(1, 3);
        end
        else if (sel < 14)
        begin
            m = $urandom_range(5, imm_pkg::MAX_DIM);
            inner = $urandom_range(5, imm_pkg::MAX_DIM);
            inner_r = inner;
            n = $urandom_range(5, imm_pkg::MAX_DIM);
        end
        else if (sel < 17)
        begin
            m = $urandom_range(0, imm_pkg::MAX_DIM);
            n = $urandom_range(0, imm_pkg::MAX_DIM);
            inner = $urandom_range(0, imm_pkg::MAX_DIM);
            do inner_r = $urandom_range(0, imm_pkg::MAX_DIM); while (inner_r == inner);
        end
        else
        begin
            inner = $urandom_range(0, imm_pkg::MAX_DIM);
            inner_r = inner;
            m = $urandom_range(0, imm_pkg::MAX_DIM);
            n = $urandom_range(0, imm_pkg::MAX_DIM);
            if ($urandom_range(0, 1) == 1) m = 0;
            else n = 0;
        end
        idle_on = pressure || ($urandom_range(0, 2) != 0);
        set_sizes(raw_size(m), raw_size(inner), raw_size(inner_r), raw_size(n));

        // never-written entries that the multiply reads must be loaded;
        // written ones are refreshed now and then
        if (inner == inner_r && m != 0 && n != 0)
        begin
            for (int i = 0; i < m; i++)
                for (int k = 0; k < inner; k++)
                begin
                    a = imm_pkg::addr_t'(i * imm_pkg::MAX_DIM + k);
                    if (!lhs_set[a] || $urandom_range(0, 3) == 0)
                        pending.push_back('{imm_pkg::KIND_LOAD_LHS, a});
                end
            for (int k = 0; k < inner; k++)
                for (int j = 0; j < n; j++)
                begin
                    a = imm_pkg::addr_t'(k * imm_pkg::MAX_DIM + j);
                    if (!rhs_set[a] || $urandom_range(0, 3) == 0)
                        pending.push_back('{imm_pkg::KIND_LOAD_RHS, a});
                end
        end
        // stray loads anywhere in the store, outside the configured size too
        repeat ($urandom_range(0, 2))
            pending.push_back('{($urandom_range(0, 1) == 1) ? imm_pkg::KIND_LOAD_RHS
                                                            : imm_pkg::KIND_LOAD_LHS,
                                imm_pkg::addr_t'($urandom)});
        for (int i = pending.size() - 1; i > 0; i--)
        begin
            pick = $urandom_range(0, i);
            swap = pending[i];
            pending[i] = pending[pick];
            pending[pick] = swap;
        end

        // the receiver stalls long while starts keep coming
        if (pressure)
            hold_req = 1'b1;
        foreach (pending[i])
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(KIND_UNUSED, imm_pkg::idx_t'($urandom), imm_pkg::idx_t'($urandom),
                          $urandom);
            send_item(pending[i].kind, pending[i].addr[imm_pkg::ADDR_W-1:imm_pkg::IDX_W],
                      pending[i].addr[imm_pkg::IDX_W-1:0], pick_value());
        end
        starts = pressure ? 3 : (($urandom_range(0, 3) == 0) ? 2 : 1);
        repeat (starts)
            send_item(imm_pkg::KIND_START, imm_pkg::idx_t'($urandom),
                      imm_pkg::idx_t'($urandom), $urandom);
        if (pressure)
            repeat (4)
                send_item(($urandom_range(0, 1) == 1) ? imm_pkg::KIND_LOAD_RHS
                                                      : imm_pkg::KIND_LOAD_LHS,
                          imm_pkg::idx_t'($urandom), imm_pkg::idx_t'($urandom), pick_value());
    endtask

    // ------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------
    function automatic step_t sizes_step(input size_t lr, input size_t lc, input size_t rr,
                                         input size_t rc);
        return '{ACT_SIZES, lr, lc, rr, rc, imm_pkg::KIND_START, '0, '0, '0, 1'b0,
                 imm_pkg::STATUS_OK, '0};
    endfunction

    function automatic step_t item_step(input logic [imm_pkg::KIND_W-1:0] kind,
                                        input imm_pkg::idx_t row, input imm_pkg::idx_t col,
                                        input imm_pkg::word_t value);
        return '{ACT_ITEM, '0, '0, '0, '0, kind, row, col, value, 1'b0, imm_pkg::STATUS_OK, '0};
    endfunction

    // start whose single result is written down here
    function automatic step_t start_expect(input logic [imm_pkg::STATUS_W-1:0] status,
                                           input imm_pkg::word_t element);
        return '{ACT_ITEM, '0, '0, '0, '0, imm_pkg::KIND_START, '0, '0, '0, 1'b1, status,
                 element};
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        step_t directed [$];
        int    base;
        directed = '{
            // all sizes reset to zero: the sizes match and the product is empty
            start_expect(imm_pkg::STATUS_EMPTY, '0),
            sizes_step(1, 1, 1, 1),
            item_step(imm_pkg::KIND_LOAD_LHS, 0, 0, 32'h7FFF_FFFF),
            item_step(imm_pkg::KIND_LOAD_RHS, 0, 0, 32'h7FFF_FFFF),
            start_expect(imm_pkg::STATUS_OK, 32'h0000_0001),      // max * max wraps to 1
            item_step(imm_pkg::KIND_LOAD_LHS, 0, 0, 32'h8000_0000),
            start_expect(imm_pkg::STATUS_OK, 32'h8000_0000),      // min * max
            item_step(imm_pkg::KIND_LOAD_RHS, 0, 0, 32'h8000_0000),
            start_expect(imm_pkg::STATUS_OK, 32'h0000_0000),      // min * min
            item_step(imm_pkg::KIND_LOAD_LHS, 0, 0, 32'hFFFF_FFFF),
            // loads at the far corner lie outside the 1x1 size but are stored
            item_step(imm_pkg::KIND_LOAD_LHS, 7, 7, 32'hFFFF_FFFF),
            item_step(imm_pkg::KIND_LOAD_RHS, 7, 7, 32'hFFFF_FFFF),
            // unused kind at (0,0): taken as a load it would make the product 0
            item_step(KIND_UNUSED, 0, 0, 32'h0000_0002),
            start_expect(imm_pkg::STATUS_OK, 32'h8000_0000),      // -1 * min
            sizes_step(2, 3, 2, 2),
            start_expect(imm_pkg::STATUS_MISMATCH, '0),
            sizes_step(0, 3, 3, 2),
            start_expect(imm_pkg::STATUS_EMPTY, '0),
            // 12 acts as 8 in the size check, so this is empty, not a mismatch
            sizes_step(0, 12, 8, 0),
            start_expect(imm_pkg::STATUS_EMPTY, '0),
            // zero inner size at oversized outer sizes: 64 zero elements
            sizes_step(15, 0, 0, 15),
            item_step(imm_pkg::KIND_START, 7, 7, 32'hFFFF_FFFF),
            sizes_step(2, 0, 0, 3),
            item_step(imm_pkg::KIND_START, 0, 0, '0),
            sizes_step(2, 2, 2, 2),
            item_step(imm_pkg::KIND_LOAD_LHS, 0, 1, 32'd3),
            item_step(imm_pkg::KIND_LOAD_LHS, 1, 0, 32'hFFFF_FFFB),
            item_step(imm_pkg::KIND_LOAD_LHS, 1, 1, 32'h4000_0001),
            item_step(imm_pkg::KIND_LOAD_RHS, 0, 1, 32'd7),
            item_step(imm_pkg::KIND_LOAD_RHS, 1, 0, 32'h0001_0000),
            item_step(imm_pkg::KIND_LOAD_RHS, 1, 1, 32'hFFFF_FFFE),
            item_step(imm_pkg::KIND_START, 0, 0, '0)
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            if (directed[i].act == ACT_SIZES)
                set_sizes(directed[i].lhs_rows, directed[i].lhs_cols,
                          directed[i].rhs_rows, directed[i].rhs_cols);
            else if (directed[i].typed)
            begin
                send_item(directed[i].kind, directed[i].row, directed[i].col,
                          directed[i].value, 1'b0);
                expected_products.push_back('{directed[i].status, '0, '0,
                                              directed[i].element, 1'b1});
            end
            else
                send_item(directed[i].kind, directed[i].row, directed[i].col, directed[i].value);
        end

        // random runs; one of them holds the output off for a long stretch
        base = items_in;
        while (items_in - base < RANDOM_ITEMS)
        begin
            no_idle = (items_in - base >= RANDOM_ITEMS - NO_IDLE_TAIL);
            run_phase(!hold_req && (items_in - base >= RANDOM_ITEMS / 3));
        end

        // drain: all products back, then a latency's worth of quiet
        s_tvalid <= 1'b0;
        while (expected_products.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run: %0d items in, %0d starts, %0d size settings", items_in, starts_in,
                 size_settings);
        $display("     %0d results checked, %0d mismatch runs, %0d empty runs", products_seen,
                 mismatch_runs, empty_runs);
        if (fail_count == 0)
            $display("integer_matrix_multiply verification clean");
        else
            $display("integer_matrix_multiply verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Output side: random back-pressure, one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        forever
        begin
            if (hold_req && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // compare each accepted product with the oldest expectation
    always @(posedge clk)
    begin
        product_t got;
        product_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tuser, m_tdata[imm_pkg::IDX_W-1:0],
                    m_tdata[2*imm_pkg::IDX_W-1:imm_pkg::IDX_W],
                    m_tdata[2*imm_pkg::IDX_W+imm_pkg::DATA_W-1:2*imm_pkg::IDX_W], m_tlast};
            products_seen++;
            if (got.status == imm_pkg::STATUS_MISMATCH) mismatch_runs++;
            if (got.status == imm_pkg::STATUS_EMPTY) empty_runs++;
            if (expected_products.size() == 0)
            begin
                fail_count++;
                if (reported < REPORT_LIMIT)
                begin
                    reported++;
                    $display("unexpected result: status %0d row %0d col %0d element %h last %0b",
                             got.status, got.row, got.col, got.element, got.last);
                end
            end
            else
            begin
                want = expected_products.pop_front();
                if (got.status !== want.status || got.row !== want.row || got.col !== want.col
                    || got.element !== want.element || got.last !== want.last)
                begin
                    fail_count++;
                    if (reported < REPORT_LIMIT)
                    begin
                        reported++;
                        $display("result mismatch at %0t", $realtime);
                        $display("  expected: status %0d row %0d col %0d element %h last %0b",
                                 want.status, want.row, want.col, want.element, want.last);
                        $display("  actual:   status %0d row %0d col %0d element %h last %0b",
                                 got.status, got.row, got.col, got.element, got.last);
                    end
                end
            end
        end
    end

    // watchdog: too long with no handshake on any port ends the run
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: %0d cycles without a handshake, %0d results outstanding",
                     quiet_cycles, expected_products.size());
            $display("integer_matrix_multiply verification failed");
            $finish;
        end
    end

endmodule
